// ===== rtl/sts_pkg.sv =====
package sts_pkg;

  localparam int FRAC_BITS = 16;
  localparam int MAX_TERMS = 32;
  localparam int IN_W      = 22;
  localparam int OUT_W     = 40;
  localparam int THR_W     = 16;

  localparam int MAG_W     = IN_W;
  localparam int MAGV_W    = FRAC_BITS + 5;
  localparam int SQ_W      = FRAC_BITS + 9;
  localparam int TM_W      = OUT_W;
  localparam int TH_W      = TM_W / 2;
  localparam int PP_W      = (TM_W - TH_W) + SQ_W;
  localparam int PROD_W    = TM_W + SQ_W;
  localparam int DVD_W     = PROD_W - FRAC_BITS;
  localparam int SUM_W     = DVD_W + 1;
  localparam int RADIX_B   = 4;
  localparam int DIV_CYC   = (DVD_W + RADIX_B - 1) / RADIX_B;
  localparam int QP_W      = DIV_CYC * RADIX_B;
  localparam int DCW       = $clog2(DIV_CYC);
  localparam int KW        = $clog2(MAX_TERMS + 1);
  localparam int DIV_W     = $clog2((2 * MAX_TERMS - 2) * (2 * MAX_TERMS - 1) + 1);

  localparam logic [MAG_W-1:0] ARG_LIMIT = MAG_W'(16) << FRAC_BITS;
  localparam logic [SUM_W-1:0] OUT_MAX   = {{(SUM_W - OUT_W + 1){1'b0}}, {(OUT_W - 1){1'b1}}};
  localparam logic [OUT_W-1:0] SAT_POS   = {1'b0, {(OUT_W - 1){1'b1}}};
  localparam logic [OUT_W-1:0] SAT_NEG   = {1'b1, {(OUT_W - 1){1'b0}}};

  typedef struct packed {
    logic load;
    logic square;
    logic mul_lo;
    logic mul_hi;
    logic mul_add;
    logic div_load;
    logic div_step;
    logic acc;
    logic emit;
  } sts_cmd_t;

  typedef struct packed {
    logic arg_big;
    logic ovf;
    logic more;
  } sts_stat_t;

endpackage

// ===== rtl/sinh_taylor_series.sv =====
// Per request: the square, then for each series term (n terms added, 1..31) the split 40x25
// multiply and divide setup, the radix-16 divider and the accumulate, then the output.
// An oversized argument skips the series and goes straight to the saturated output.
// One request at a time (busy while working); the next is taken in the strobe cycle.
// Reset (rst_n, sync, active low) idles the controller and sets stop_threshold to 1.
// Results are strobed for one cycle; the receiver cannot stall.
module sinh_taylor_series (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [sts_pkg::IN_W-1:0]    in_x_value,
  output logic                               out_strobe,
  output logic signed [sts_pkg::OUT_W-1:0]   out_sinh_value,
  output logic                               out_range_error,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sts_pkg::THR_W-1:0]          cfg_stop_threshold
);
  import sts_pkg::*;

  sts_cmd_t  cmd;
  sts_stat_t stat;

  assign cfg_ready = 1'b1;

  sts_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .out_strobe (out_strobe),
    .cmd        (cmd),
    .stat       (stat)
  );

  sts_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_we      (cfg_valid & cfg_ready),
    .cfg_thr     (cfg_stop_threshold),
    .x_value     (in_x_value),
    .sinh_value  (out_sinh_value),
    .range_error (out_range_error)
  );

  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe longer than one cycle");

  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_range_error) |->
      (out_sinh_value == SAT_POS || out_sinh_value == SAT_NEG))
    else $error("range error without saturated value");

  a_one_cmd_stage: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.square, cmd.mul_lo, cmd.mul_hi, cmd.mul_add,
              cmd.div_load, cmd.div_step, cmd.acc, cmd.emit}))
    else $error("conflicting datapath commands");

endmodule

// ===== rtl/sts_dp.sv =====
module sts_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sts_pkg::sts_cmd_t             cmd,
  output sts_pkg::sts_stat_t            stat,
  input  logic                          cfg_we,
  input  logic [sts_pkg::THR_W-1:0]     cfg_thr,
  input  logic signed [sts_pkg::IN_W-1:0] x_value,
  output logic signed [sts_pkg::OUT_W-1:0] sinh_value,
  output logic                          range_error
);
  import sts_pkg::*;

  logic [THR_W-1:0]   thr_r;
  logic               neg_r;
  logic [MAG_W-1:0]   mag_r;
  logic [MAG_W-1:0]   mag_nxt;
  logic               arg_big_r;
  logic               ovf_r;
  logic [SQ_W-1:0]    sq_r;
  logic [2*MAGV_W-1:0] sq_full;
  logic [DVD_W-1:0]   term_r;
  logic [SUM_W-1:0]   sum_r;
  logic [SUM_W-1:0]   sum_nxt;
  logic [KW-1:0]      k_r;
  logic [KW-1:0]      k_inc;
  logic [PP_W-1:0]    pp_r;
  logic [PROD_W-1:0]  acc_r;
  logic [QP_W-1:0]    quo_r;
  logic [QP_W-1:0]    quo_v;
  logic [DIV_W-1:0]   rem_r;
  logic [DIV_W-1:0]   rem_v;
  logic [DIV_W:0]     r_ext;
  logic [DIV_W-1:0]   dvs_r;
  logic [2*KW+1:0]    dvs_full;
  logic [DVD_W-1:0]   quo_term;
  logic               err;
  logic [OUT_W-1:0]   mag_out;
  logic [OUT_W-1:0]   out_r;
  logic               err_out_r;

  assign mag_nxt  = x_value[IN_W-1] ? (~x_value + 1'b1) : x_value;
  assign sq_full  = mag_r[MAGV_W-1:0] * mag_r[MAGV_W-1:0];
  assign dvs_full = {k_r, 1'b0} * {k_r, 1'b1};
  assign quo_term = quo_r[DVD_W-1:0];
  assign sum_nxt  = sum_r + {1'b0, quo_term};
  assign k_inc    = k_r + 1'b1;

  always_comb begin
    rem_v = rem_r;
    quo_v = quo_r;
    r_ext = '0;
    for (int i = 0; i < RADIX_B; i++) begin
      r_ext = {rem_v, quo_v[QP_W-1]};
      quo_v = {quo_v[QP_W-2:0], 1'b0};
      if (r_ext >= {1'b0, dvs_r}) begin
        rem_v    = DIV_W'(r_ext - {1'b0, dvs_r});
        quo_v[0] = 1'b1;
      end else begin
        rem_v = r_ext[DIV_W-1:0];
      end
    end
  end

  assign stat.arg_big = arg_big_r;
  assign stat.ovf     = sum_nxt > OUT_MAX;
  assign stat.more    = (quo_term >= {{(DVD_W - THR_W){1'b0}}, thr_r}) &&
                        (k_inc < KW'(MAX_TERMS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_W'(1);
    end else if (cfg_we) begin
      thr_r <= cfg_thr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg_r     <= x_value[IN_W-1];
      mag_r     <= mag_nxt;
      arg_big_r <= mag_nxt > ARG_LIMIT;
      ovf_r     <= 1'b0;
    end
    if (cmd.square) begin
      sq_r   <= sq_full[FRAC_BITS +: SQ_W];
      term_r <= {{(DVD_W - MAGV_W){1'b0}}, mag_r[MAGV_W-1:0]};
      sum_r  <= {{(SUM_W - MAGV_W){1'b0}}, mag_r[MAGV_W-1:0]};
      k_r    <= KW'(1);
    end
    if (cmd.mul_lo) begin
      pp_r <= PP_W'(term_r[TH_W-1:0] * sq_r);
    end
    if (cmd.mul_hi) begin
      acc_r <= {{(PROD_W - PP_W){1'b0}}, pp_r};
      pp_r  <= PP_W'(term_r[TM_W-1:TH_W] * sq_r);
    end
    if (cmd.mul_add) begin
      acc_r <= acc_r + ({{(PROD_W - PP_W){1'b0}}, pp_r} << TH_W);
    end
    if (cmd.div_load) begin
      quo_r <= {{(QP_W - DVD_W){1'b0}}, acc_r[PROD_W-1:FRAC_BITS]};
      rem_r <= '0;
      dvs_r <= dvs_full[DIV_W-1:0];
    end
    if (cmd.div_step) begin
      quo_r <= quo_v;
      rem_r <= rem_v;
    end
    if (cmd.acc) begin
      term_r <= quo_term;
      sum_r  <= sum_nxt;
      k_r    <= k_inc;
      ovf_r  <= sum_nxt > OUT_MAX;
    end
    if (cmd.emit) begin
      out_r     <= err ? (neg_r ? SAT_NEG : SAT_POS) : (neg_r ? (~mag_out + 1'b1) : mag_out);
      err_out_r <= err;
    end
  end

  assign err     = arg_big_r | ovf_r;
  assign mag_out = sum_r[OUT_W-1:0];

  assign sinh_value  = out_r;
  assign range_error = err_out_r;

endmodule

// ===== rtl/sts_ctrl.sv =====
module sts_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  output logic                out_strobe,
  output sts_pkg::sts_cmd_t   cmd,
  input  sts_pkg::sts_stat_t  stat
);
  import sts_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SQ   = 4'd1;
  localparam logic [3:0] S_MLO  = 4'd2;
  localparam logic [3:0] S_MHI  = 4'd3;
  localparam logic [3:0] S_MADD = 4'd4;
  localparam logic [3:0] S_DLD  = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_ACC  = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [3:0]     state_r;
  logic [3:0]     state_nxt;
  logic [DCW-1:0] dcnt_r;
  logic [DCW-1:0] dcnt_nxt;
  logic           strobe_r;

  always_comb begin
    state_nxt = state_r;
    dcnt_nxt  = dcnt_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        cmd.square = 1'b1;
        state_nxt  = stat.arg_big ? S_OUT : S_MLO;
      end
      S_MLO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = S_MHI;
      end
      S_MHI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = S_MADD;
      end
      S_MADD: begin
        cmd.mul_add = 1'b1;
        state_nxt   = S_DLD;
      end
      S_DLD: begin
        cmd.div_load = 1'b1;
        dcnt_nxt     = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        dcnt_nxt     = dcnt_r + 1'b1;
        if (dcnt_r == DCW'(DIV_CYC - 1)) begin
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = (stat.ovf || !stat.more) ? S_OUT : S_MLO;
      end
      S_OUT: begin
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      dcnt_r   <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      dcnt_r   <= dcnt_nxt;
      strobe_r <= cmd.emit;
    end
  end

  assign busy       = state_r != S_IDLE;
  assign out_strobe = strobe_r;

endmodule
